/* design/minicomputer_subset_instruction_executor_macros.svh */
// Assertion macros for the instruction executor.
// Included by modules that carry concurrent assertions.
`ifndef MINICOMPUTER_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define MINICOMPUTER_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MSIE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MSIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/msie_pkg.sv */
// Shared types and constants for the instruction executor.
// No dependencies.
`timescale 1ns / 1ps
package msie_pkg;
   localparam int ADDR_BITS = 16;

   typedef enum logic [2:0] {
      OP_WR_MEM = 3'd0,
      OP_RD_MEM = 3'd1,
      OP_RD_REG = 3'd2,
      OP_WR_REG = 3'd3,
      OP_EXEC   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_HALT   = 2'd1,
      ST_BADMOD = 2'd2,
      ST_REFUSE = 2'd3
   } status_type;

   // instruction encodings: opcode fields and the halt word
   localparam logic [3:0]  INS_MOV  = 4'o01;
   localparam logic [3:0]  INS_MOVB = 4'o11;
   localparam logic [3:0]  INS_ADD  = 4'o06;
   localparam logic [9:0]  INS_INC  = 10'o0052;
   localparam logic [9:0]  INS_CLR  = 10'o0050;
   localparam logic [9:0]  INS_CLRB = 10'o1050;
   localparam logic [6:0]  INS_SOB  = 7'o077;
   localparam logic [15:0] W_HALT   = 16'o000000;

   // supported addressing modes
   localparam logic [2:0] MODE_REG     = 3'd0;
   localparam logic [2:0] MODE_DEF     = 3'd1;
   localparam logic [2:0] MODE_AUTOINC = 3'd2;
   localparam logic [2:0] MODE_AUTODEC = 3'd4;

   // shared adder operation
   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [15:0] a;
      logic [15:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] sum;
      logic carry;
   } alu_rsp_type;
endpackage

/* design/msie_alu.sv */
// Shared 16-bit adder/subtractor used for every address step and sum.
// Depends on msie_pkg.
`timescale 1ns / 1ps
module msie_alu import msie_pkg::*; (
   input  alu_req_type req,
   output alu_rsp_type rsp
);
   logic [16:0] full;
   // add or subtract with 17-bit result
   always_comb begin
      unique case (req.op)
         ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
         default: full = {1'b0, req.a} + {1'b0, req.b};
      endcase
      rsp.sum = full[15:0];
      rsp.carry = full[16];
   end
endmodule

/* design/minicomputer_subset_instruction_executor.sv */
// Top level of the instruction executor: sequencer, registers, byte memory.
// Depends on msie_pkg, msie_alu and the assertion macro header.
// Channel | ports                                   | direction
// req     | req_valid/ready, operation, address, wv | in
// rsp     | rsp_valid/ready, read_value, status,    | out
//         | program_counter, n/z/c flags            |
// Response time depends on the operation. Execute time is set by the byte-wide memory
// port (a byte read passes the read and wait states, a byte write the write state)
// and by the one shared adder that steps the PC and the operand registers.
// Synchronous reset clears registers, flags and halted; memory is undefined.
// The result holds until rsp_ready; req_ready returns the cycle after the handshake.
`timescale 1ns / 1ps
`include "minicomputer_subset_instruction_executor_macros.svh"
module minicomputer_subset_instruction_executor import msie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [15:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_program_counter,
   output logic        rsp_negative_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_carry_flag
);
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_DISP  = 14'b00000000000010,
      S_MRD   = 14'b00000000000100, // read byte at maddr_ff
      S_MRDW  = 14'b00000000001000, // read-data wait
      S_MWR   = 14'b00000000010000, // write byte
      S_DEC   = 14'b00000000100000, // decode fetched word
      S_OPPRE = 14'b00000001000000, // operand pre-decrement
      S_OPADR = 14'b00000010000000, // operand address / register read
      S_OPPOS = 14'b00000100000000, // operand post-increment, operand done
      S_EXE   = 14'b00001000000000, // compute result
      S_WB    = 14'b00010000000000, // write back
      S_SOB   = 14'b00100000000000, // sob branch
      S_PCINC = 14'b01000000000000, // pc + 2
      S_RSP   = 14'b10000000000000
   } state_type;

   typedef enum logic [1:0] {
      RT_HOSTRD = 2'd0, RT_FETCH = 2'd1, RT_SRC = 2'd2, RT_DST = 2'd3
   } ret_type;

   localparam logic [ADDR_BITS-1:0] AMASK = '1;

   state_type   state_ff;
   logic [15:0] regs_ff [8];
   logic        n_ff, z_ff, c_ff, halt_ff;
   logic [7:0]  mem [2**ADDR_BITS];
   logic [7:0]  mrd_ff;
   logic [15:0] maddr_ff;
   logic        mhi_ff;      // second byte of a word access
   logic        mword_ff;    // word access
   logic [15:0] mdata_ff;    // data assembled or to write
   ret_type     ret_ff;
   logic [2:0]  op_ff;
   logic [15:0] addr_ff, wv_ff, iw_ff;
   logic        phase_ff;    // 0 source operand, 1 destination
   logic        mdone_ff;    // autodecrement already applied to this operand
   logic [15:0] srcv_ff, dstv_ff, dloc_ff;
   logic        disreg_ff;
   logic [15:0] rd_ff;
   status_type  st_ff;
   logic        rsp_valid_ff;

   // decode helpers
   logic is_dbl, is_add, is_one, is_inc, is_sob, bytem;
   logic [5:0] spec;
   logic [2:0] rn, md;
   logic [15:0] step;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   assign bytem  = iw_ff[15];
   assign is_dbl = (iw_ff[15:12] == INS_MOVB) || (iw_ff[15:12] == INS_MOV) ||
                   (iw_ff[15:12] == INS_ADD);
   assign is_add = iw_ff[15:12] == INS_ADD;
   assign is_inc = iw_ff[15:6] == INS_INC;
   assign is_one = is_inc || (iw_ff[15:6] == INS_CLRB) || (iw_ff[15:6] == INS_CLR);
   assign is_sob = iw_ff[15:9] == INS_SOB;
   assign spec   = (is_dbl && !phase_ff) ? iw_ff[11:6] : iw_ff[5:0];
   assign rn     = spec[2:0];
   assign md     = spec[5:3];
   assign step   = (bytem && !is_add && rn < 3'd6) ? 16'd1 : 16'd2;

   function automatic logic mode_ok(input logic [2:0] m);
      mode_ok = (m == MODE_REG) || (m == MODE_DEF) || (m == MODE_AUTOINC) ||
                (m == MODE_AUTODEC);
   endfunction

   msie_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   // pick adder operands by state
   always_comb begin
      alu_req = '{op: ALU_ADD, a: 16'd0, b: 16'd0};
      unique case (state_ff)
         S_OPPRE: alu_req = '{op: ALU_SUB, a: regs_ff[rn], b: step};
         S_OPPOS: alu_req = '{op: ALU_ADD, a: regs_ff[rn], b: step};
         S_PCINC: alu_req = '{op: ALU_ADD, a: regs_ff[7], b: 16'd2};
         S_EXE: begin
            if (is_add) alu_req = '{op: ALU_ADD, a: srcv_ff, b: dstv_ff};
            else if (is_inc) alu_req = '{op: ALU_ADD, a: dstv_ff, b: 16'd1};
            else if (is_sob) alu_req = '{op: ALU_SUB, a: regs_ff[iw_ff[8:6]], b: 16'd1};
         end
         S_SOB: alu_req = '{op: ALU_SUB, a: regs_ff[7], b: {9'd0, iw_ff[5:0], 1'b0}};
         default: ;
      endcase
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_status = st_ff;
   assign rsp_program_counter = regs_ff[7];
   assign rsp_negative_flag = n_ff;
   assign rsp_zero_flag = z_ff;
   assign rsp_carry_flag = c_ff;

   // memory port: one byte read or write per cycle, registered read data
   logic mem_we;
   logic [ADDR_BITS-1:0] mem_a;
   assign mem_we = state_ff == S_MWR;
   assign mem_a  = (maddr_ff[ADDR_BITS-1:0] & AMASK) |
                   ADDR_BITS'(mword_ff ? {15'd0, mhi_ff} : 16'd0);
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_a] <= mhi_ff ? mdata_ff[15:8] : mdata_ff[7:0];
      mrd_ff <= mem[mem_a];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         n_ff <= 1'b0; z_ff <= 1'b0; c_ff <= 1'b0; halt_ff <= 1'b0;
         mdone_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               op_ff <= req_operation; addr_ff <= req_address; wv_ff <= req_write_value;
               state_ff <= S_DISP;
            end
            S_DISP: begin
               rd_ff <= (op_ff == OP_RD_REG) ? regs_ff[addr_ff[2:0]] : 16'd0;
               st_ff <= (op_ff == OP_EXEC && halt_ff) ? ST_REFUSE : ST_DONE;
               mword_ff <= 1'b1; mhi_ff <= 1'b0;
               maddr_ff <= (op_ff == OP_EXEC) ? {regs_ff[7][15:1], 1'b0} :
                                                {addr_ff[15:1], 1'b0};
               unique case (op_ff)
                  OP_WR_MEM: begin mdata_ff <= wv_ff; state_ff <= S_MWR; end
                  OP_RD_MEM: begin ret_ff <= RT_HOSTRD; state_ff <= S_MRD; end
                  OP_RD_REG: state_ff <= S_RSP;
                  OP_WR_REG: begin regs_ff[addr_ff[2:0]] <= wv_ff; state_ff <= S_RSP; end
                  OP_EXEC: begin
                     if (halt_ff) begin
                        state_ff <= S_RSP;
                     end else begin
                        ret_ff <= RT_FETCH; state_ff <= S_MRD;
                     end
                  end
                  default: state_ff <= S_RSP;
               endcase
            end
            S_MRD: state_ff <= S_MRDW;
            S_MRDW: begin
               // keep the low byte of a word, then finish the access
               if (mword_ff && !mhi_ff) begin
                  mdata_ff <= {8'd0, mrd_ff};
                  mhi_ff <= 1'b1; state_ff <= S_MRD;
               end else begin
                  unique case (ret_ff)
                     RT_HOSTRD: begin rd_ff <= {mrd_ff, mdata_ff[7:0]}; state_ff <= S_RSP; end
                     RT_FETCH: begin
                        iw_ff <= {mrd_ff, mdata_ff[7:0]}; state_ff <= S_PCINC;
                     end
                     RT_SRC: begin
                        srcv_ff <= mword_ff ? {mrd_ff, mdata_ff[7:0]} : {8'd0, mrd_ff};
                        state_ff <= S_OPPOS;
                     end
                     default: begin
                        dstv_ff <= mword_ff ? {mrd_ff, mdata_ff[7:0]} : {8'd0, mrd_ff};
                        state_ff <= S_OPPOS;
                     end
                  endcase
               end
            end
            S_PCINC: begin
               regs_ff[7] <= alu_rsp.sum;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (is_dbl || is_one) begin
                  if (!mode_ok(iw_ff[5:3]) || (is_dbl && !mode_ok(iw_ff[11:9]))) begin
                     halt_ff <= 1'b1; st_ff <= ST_BADMOD; state_ff <= S_RSP;
                  end else begin
                     phase_ff <= !is_dbl; mdone_ff <= 1'b0; state_ff <= S_OPADR;
                  end
               end else if (iw_ff == W_HALT) begin
                  halt_ff <= 1'b1; st_ff <= ST_HALT; state_ff <= S_RSP;
               end else if (is_sob) begin
                  state_ff <= S_EXE;
               end else begin
                  state_ff <= S_RSP;
               end
            end
            S_OPADR: begin
               // one operand: register read, predecrement or memory read
               if (md == MODE_REG) begin
                  if (phase_ff) begin
                     dstv_ff <= regs_ff[rn]; disreg_ff <= 1'b1;
                     dloc_ff <= {13'd0, rn}; state_ff <= S_EXE;
                  end else begin
                     srcv_ff <= regs_ff[rn]; phase_ff <= 1'b1;
                  end
               end else if (md == MODE_AUTODEC && !mdone_ff) begin
                  state_ff <= S_OPPRE;
               end else begin
                  maddr_ff <= bytem ? regs_ff[rn] : {regs_ff[rn][15:1], 1'b0};
                  mword_ff <= !bytem; mhi_ff <= 1'b0;
                  ret_ff <= phase_ff ? RT_DST : RT_SRC;
                  if (phase_ff) begin disreg_ff <= 1'b0; dloc_ff <= regs_ff[rn]; end
                  state_ff <= S_MRD;
               end
            end
            S_OPPRE: begin
               // step the register down before the read
               regs_ff[rn] <= alu_rsp.sum; mdone_ff <= 1'b1;
               state_ff <= S_OPADR;
            end
            S_OPPOS: begin
               // step the register up after an autoincrement read, then advance
               if (md == MODE_AUTOINC) regs_ff[rn] <= alu_rsp.sum;
               mdone_ff <= 1'b0;
               if (phase_ff) state_ff <= S_EXE;
               else begin phase_ff <= 1'b1; state_ff <= S_OPADR; end
            end
            S_EXE: begin
               if (is_sob) begin
                  regs_ff[iw_ff[8:6]] <= alu_rsp.sum;
                  state_ff <= (alu_rsp.sum != 16'd0) ? S_SOB : S_RSP;
               end else begin
                  state_ff <= S_WB;
                  if (is_add || is_inc) begin
                     mdata_ff <= alu_rsp.sum;
                     n_ff <= alu_rsp.sum[15]; z_ff <= alu_rsp.sum == 16'd0;
                     if (is_add) c_ff <= alu_rsp.carry;
                  end else if (is_one) begin
                     mdata_ff <= 16'd0; n_ff <= 1'b0; z_ff <= 1'b1; c_ff <= 1'b0;
                  end else begin
                     mdata_ff <= srcv_ff;
                     n_ff <= bytem ? srcv_ff[7] : srcv_ff[15];
                     z_ff <= bytem ? (srcv_ff[7:0] == 8'd0) : (srcv_ff == 16'd0);
                  end
               end
            end
            S_WB: begin
               // write back: register directly, memory through the byte port
               if (disreg_ff) begin
                  if (!bytem || is_add || is_inc) regs_ff[dloc_ff[2:0]] <= mdata_ff;
                  else if (!is_one) regs_ff[dloc_ff[2:0]] <= {{8{mdata_ff[7]}}, mdata_ff[7:0]};
                  else regs_ff[dloc_ff[2:0]] <= {regs_ff[dloc_ff[2:0]][15:8], 8'd0};
                  state_ff <= S_RSP;
               end else begin
                  mword_ff <= !bytem || is_add || is_inc; mhi_ff <= 1'b0;
                  maddr_ff <= (!bytem || is_add || is_inc) ? {dloc_ff[15:1], 1'b0} : dloc_ff;
                  state_ff <= S_MWR;
               end
            end
            S_MWR: begin
               if (mword_ff && !mhi_ff) mhi_ff <= 1'b1;
               else state_ff <= S_RSP;
            end
            S_SOB: begin
               regs_ff[7] <= alu_rsp.sum; state_ff <= S_RSP;
            end
            S_RSP: begin
               if (!rsp_valid_ff) rsp_valid_ff <= 1'b1;
               else if (rsp_ready) begin rsp_valid_ff <= 1'b0; state_ff <= S_IDLE; end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MSIE_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `MSIE_ASSERT_IMP(a_rsp_only_in_rsp, clock, reset, rsp_valid_ff, state_ff == S_RSP)
   `MSIE_ASSERT_NEXT(a_halt_sticks, clock, reset, halt_ff, halt_ff)
   `MSIE_ASSERT_IMP(a_ready_no_rsp, clock, reset, req_ready, !rsp_valid_ff)
endmodule

/* test/minicomputer_subset_instruction_executor_tb.sv */
// Self-checking testbench for the minicomputer subset instruction executor.
// Uses msie_pkg; drives host transactions and checks every response against a local predictor.
`timescale 1ns / 1ps
module minicomputer_subset_instruction_executor_tb import msie_pkg::*;;

   // test-only encodings and memory windows
   localparam logic [15:0] W_BADMODE = 16'o013000;
   localparam logic [15:0] CODE_BASE = 16'h2000;
   localparam logic [15:0] DATA_BASE = 16'h4000;
   localparam int          NUM_ITEMS = 1250;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] addr;
      logic [15:0] wv;
   } host_txn_t;

   typedef struct {
      logic [15:0] rv;
      logic [1:0]  st;
      logic [15:0] pc;
      logic        n, z, c;
   } exec_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [15:0] req_address = '0;
   logic [15:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_read_value;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_program_counter;
   logic        rsp_negative_flag, rsp_zero_flag, rsp_carry_flag;

   minicomputer_subset_instruction_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_address(req_address),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_status(rsp_status),
      .rsp_program_counter(rsp_program_counter),
      .rsp_negative_flag(rsp_negative_flag), .rsp_zero_flag(rsp_zero_flag),
      .rsp_carry_flag(rsp_carry_flag)
   );

   // machine state mirrored by the predictor
   logic [7:0]  mem_img [65536];
   bit          mem_set [65536];
   logic [15:0] regs [8];
   logic [15:0] chk_regs [8];
   logic        fl_n, fl_z, fl_c;
   bit          is_halted;

   host_txn_t pend_q[$];
   exec_rsp_t resp_q[$];
   int        txn_count;
   int        errors;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [15:0] rd_word(logic [15:0] a);
      logic [15:0] e;
      e = {a[15:1], 1'b0};
      return {mem_img[e + 16'd1], mem_img[e]};
   endfunction

   function automatic bit word_known(logic [15:0] a);
      return mem_set[{a[15:1], 1'b0}] && mem_set[{a[15:1], 1'b1}];
   endfunction

   task automatic wr_word(logic [15:0] a, logic [15:0] v);
      logic [15:0] e;
      e = {a[15:1], 1'b0};
      mem_img[e] = v[7:0];
      mem_img[e + 16'd1] = v[15:8];
      mem_set[e] = 1;
      mem_set[e + 16'd1] = 1;
   endtask

   function automatic bit mode_ok(logic [2:0] m);
      return m == MODE_REG || m == MODE_DEF || m == MODE_AUTOINC || m == MODE_AUTODEC;
   endfunction

   // dry run of one operand on the scratch registers: is its memory read defined?
   function automatic bit operand_known(logic [5:0] spec, bit bm);
      logic [2:0]  rn;
      logic [15:0] step, a;
      rn = spec[2:0];
      step = (bm && rn < 3'd6) ? 16'd1 : 16'd2;
      if (spec[5:3] == MODE_REG) return 1;
      if (spec[5:3] == MODE_AUTODEC) chk_regs[rn] = chk_regs[rn] - step;
      a = chk_regs[rn];
      if (spec[5:3] == MODE_AUTOINC) chk_regs[rn] = chk_regs[rn] + step;
      return bm ? mem_set[a] : word_known(a);
   endfunction

   // true when the next instruction reads only written memory and does not halt
   function automatic bit exec_safe();
      logic [15:0] w;
      bit          bm;
      for (int i = 0; i < 8; i++) chk_regs[i] = regs[i];
      if (!word_known(chk_regs[7])) return 0;
      w = rd_word(chk_regs[7]);
      bm = w[15];
      chk_regs[7] = chk_regs[7] + 16'd2;
      if (w[15:12] == INS_MOV || w[15:12] == INS_MOVB || w[15:12] == INS_ADD) begin
         if (!mode_ok(w[11:9]) || !mode_ok(w[5:3])) return 0;
         if (!operand_known(w[11:6], bm)) return 0;
         return operand_known(w[5:0], bm);
      end
      if (w == W_HALT) return 0;
      if (w[15:6] == INS_INC || w[15:6] == INS_CLR || w[15:6] == INS_CLRB) begin
         if (!mode_ok(w[5:3])) return 0;
         return operand_known(w[5:0], bm);
      end
      return 1;
   endfunction

   task automatic fetch_operand(input logic [5:0] spec, input bit bm, output bit is_reg,
                                output logic [15:0] loc, output logic [15:0] val);
      logic [2:0]  rn;
      logic [15:0] step;
      rn = spec[2:0];
      step = (bm && rn < 3'd6) ? 16'd1 : 16'd2;
      is_reg = (spec[5:3] == MODE_REG);
      if (is_reg) begin
         loc = {13'd0, rn};
         val = regs[rn];
      end else begin
         if (spec[5:3] == MODE_AUTODEC) regs[rn] = regs[rn] - step;
         loc = regs[rn];
         val = bm ? {8'd0, mem_img[loc]} : rd_word(loc);
         if (spec[5:3] == MODE_AUTOINC) regs[rn] = regs[rn] + step;
      end
   endtask

   task automatic store_operand(bit is_reg, logic [15:0] loc, bit bm, logic [15:0] v, bit sext);
      if (is_reg) begin
         if (!bm) regs[loc[2:0]] = v;
         else if (sext) regs[loc[2:0]] = {{8{v[7]}}, v[7:0]};
         else regs[loc[2:0]] = {regs[loc[2:0]][15:8], v[7:0]};
      end else if (bm) begin
         mem_img[loc] = v[7:0];
         mem_set[loc] = 1;
      end else begin
         wr_word(loc, v);
      end
   endtask

   task automatic update_nz(logic [15:0] v, bit bm);
      fl_z = bm ? (v[7:0] == 8'd0) : (v == 16'd0);
      fl_n = bm ? v[7] : v[15];
   endtask

   task automatic execute_instr(output logic [1:0] st);
      logic [15:0] w, sl, sv, dl, dv;
      logic [16:0] sum;
      bit          bm, sr, dr;
      w = rd_word(regs[7]);
      bm = w[15];
      regs[7] = regs[7] + 16'd2;
      st = ST_DONE;
      if (w[15:12] == INS_MOV || w[15:12] == INS_MOVB || w[15:12] == INS_ADD) begin
         if (!mode_ok(w[11:9]) || !mode_ok(w[5:3])) begin
            is_halted = 1;
            st = ST_BADMOD;
            return;
         end
         fetch_operand(w[11:6], bm, sr, sl, sv);
         fetch_operand(w[5:0], bm, dr, dl, dv);
         if (w[15:12] == INS_ADD) begin
            sum = {1'b0, sv} + {1'b0, dv};
            store_operand(dr, dl, 0, sum[15:0], 0);
            update_nz(sum[15:0], 0);
            fl_c = sum[16];
         end else begin
            update_nz(sv, bm);
            store_operand(dr, dl, bm, sv, 1);
         end
      end else if (w == W_HALT) begin
         is_halted = 1;
         st = ST_HALT;
      end else if (w[15:6] == INS_INC || w[15:6] == INS_CLR || w[15:6] == INS_CLRB) begin
         if (!mode_ok(w[5:3])) begin
            is_halted = 1;
            st = ST_BADMOD;
            return;
         end
         fetch_operand(w[5:0], bm, dr, dl, dv);
         if (w[15:6] == INS_INC) begin
            store_operand(dr, dl, 0, dv + 16'd1, 0);
            update_nz(dv + 16'd1, 0);
         end else begin
            store_operand(dr, dl, bm, 16'd0, 0);
            fl_n = 0;
            fl_z = 1;
            fl_c = 0;
         end
      end else if (w[15:9] == INS_SOB) begin
         regs[w[8:6]] = regs[w[8:6]] - 16'd1;
         if (regs[w[8:6]] != 16'd0) regs[7] = regs[7] - {9'd0, w[5:0], 1'b0};
      end
   endtask

   // predict the response, then queue the transaction and its expectation
   task automatic send(logic [2:0] op, logic [15:0] addr, logic [15:0] wv);
      host_txn_t t;
      exec_rsp_t r;
      r.rv = '0;
      r.st = ST_DONE;
      case (op)
         OP_WR_MEM: wr_word(addr, wv);
         OP_RD_MEM: r.rv = rd_word(addr);
         OP_RD_REG: r.rv = regs[addr[2:0]];
         OP_WR_REG: regs[addr[2:0]] = wv;
         OP_EXEC: begin
            if (is_halted) r.st = ST_REFUSE;
            else execute_instr(r.st);
         end
         default: ;
      endcase
      r.pc = regs[7];
      r.n = fl_n;
      r.z = fl_z;
      r.c = fl_c;
      t.op = op;
      t.addr = addr;
      t.wv = wv;
      pend_q.push_back(t);
      resp_q.push_back(r);
      txn_count++;
   endtask

   function automatic logic [2:0] pick_mode();
      case ($urandom_range(0, 3))
         0: return MODE_REG;
         1: return MODE_DEF;
         2: return MODE_AUTOINC;
         default: return MODE_AUTODEC;
      endcase
   endfunction

   function automatic logic [2:0] pick_reg();
      return ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
   endfunction

   function automatic logic [15:0] random_instr();
      case ($urandom_range(0, 8))
         0: return {INS_MOV, pick_mode(), pick_reg(), pick_mode(), pick_reg()};
         1: return {INS_MOVB, pick_mode(), pick_reg(), pick_mode(), pick_reg()};
         2: return {INS_ADD, pick_mode(), pick_reg(), pick_mode(), pick_reg()};
         3: return {INS_INC, pick_mode(), pick_reg()};
         4: return {INS_CLR, pick_mode(), pick_reg()};
         5: return {INS_CLRB, pick_mode(), pick_reg()};
         6, 7: return {INS_SOB, 3'($urandom_range(0, 5)), 6'($urandom_range(0, 63))};
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // keep the program counter inside the initialized code window
   task automatic home_pc();
      if (regs[7] < CODE_BASE || regs[7] > CODE_BASE + 16'h00F0)
         send(OP_WR_REG, 16'd7, CODE_BASE + 16'(2 * $urandom_range(0, 120)));
   endtask

   task automatic aim_pointers(int pct);
      for (int r = 0; r < 7; r++)
         if ($urandom_range(0, 99) < pct)
            send(OP_WR_REG, 16'(r), DATA_BASE + 16'h0010 + 16'($urandom_range(0, 224)));
   endtask

   // place an instruction at the program counter and run it when it is safe
   task automatic run_instr(logic [15:0] w);
      home_pc();
      send(OP_WR_MEM, regs[7], w);
      if (exec_safe()) send(OP_EXEC, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endtask

   // stimulus generation
   initial begin
      logic [15:0] written_q[$];
      logic [15:0] a;
      bit          ok;
      for (int i = 0; i < 8; i++) regs[i] = '0;
      fl_n = 0;
      fl_z = 0;
      fl_c = 0;
      is_halted = 0;

      // initialize code and data windows
      for (int i = 0; i < 256; i += 2) begin
         send(OP_WR_MEM, CODE_BASE + 16'(i), random_instr());
         send(OP_WR_MEM, DATA_BASE + 16'(i), 16'($urandom_range(0, 65535)));
      end

      // directed: field extremes, odd word address, undefined opcodes
      send(OP_WR_MEM, 16'hFFFF, 16'hFFFF);
      send(OP_RD_MEM, 16'hFFFE, 16'h0000);
      send(OP_WR_MEM, 16'h0000, 16'h0000);
      send(OP_RD_MEM, 16'h0001, 16'hFFFF);
      send(OP_WR_REG, 16'hFFF8, 16'hFFFF);
      send(OP_RD_REG, 16'hFFF8, 16'h0000);
      send(3'd5, 16'hFFFF, 16'hFFFF);
      send(3'd7, 16'h0000, 16'h0000);
      send(OP_WR_REG, 16'd1, 16'd1);
      send(OP_WR_REG, 16'd2, DATA_BASE + 16'h0041);
      send(OP_WR_REG, 16'd6, DATA_BASE + 16'h0080);
      send(OP_WR_MEM, DATA_BASE + 16'h0040, 16'h80F0);
      // directed instructions: add with carry, byte sign extension, byte steps,
      // inc, clr, clrb on a register, sob taken and not taken, unknown word
      run_instr(16'o060001);
      run_instr(16'o111203);
      run_instr(16'o010346);
      run_instr(16'o112612);
      run_instr(16'o005201);
      run_instr(16'o005212);
      run_instr(16'o105003);
      run_instr(16'o005042);
      send(OP_WR_REG, 16'd1, 16'd3);
      run_instr(16'o077102);
      send(OP_WR_REG, 16'd1, 16'd1);
      run_instr(16'o077177);
      run_instr(16'o170000);

      // random: mostly instruction runs, mixed with host accesses and noise
      while (txn_count < NUM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               a = 16'($urandom_range(0, 65535));
               send(OP_WR_MEM, a, 16'($urandom_range(0, 65535)));
               written_q.push_back(a);
            end
            2, 3: begin
               if (written_q.size() > 0 && $urandom_range(0, 1))
                  a = written_q[$urandom_range(0, written_q.size() - 1)];
               else
                  a = ($urandom_range(0, 1) ? DATA_BASE : CODE_BASE) + 16'($urandom_range(0, 255));
               send(OP_RD_MEM, a, 16'($urandom_range(0, 65535)));
            end
            4: send(OP_RD_REG, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            5: send(OP_WR_REG, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            6: send(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
            default: begin
               home_pc();
               aim_pointers(15);
               if ($urandom_range(0, 2) == 0) send(OP_WR_MEM, regs[7], random_instr());
               ok = exec_safe();
               for (int k = 0; k < 8 && !ok; k++) begin
                  home_pc();
                  aim_pointers(100);
                  send(OP_WR_MEM, regs[7], random_instr());
                  ok = exec_safe();
               end
               if (ok) send(OP_EXEC, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
            end
         endcase
      end

      // stop the machine once, then show that execute is refused but host access works
      home_pc();
      send(OP_WR_MEM, regs[7], $urandom_range(0, 1) ? W_HALT : W_BADMODE);
      send(OP_EXEC, 16'h0000, 16'h0000);
      send(OP_EXEC, 16'hFFFF, 16'hFFFF);
      send(OP_WR_REG, 16'd3, 16'hA5A5);
      send(OP_RD_REG, 16'd3, 16'h0000);
      send(OP_RD_MEM, DATA_BASE, 16'h0000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pend_q.size() > 0 || resp_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // sender: bursts of transactions separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      host_txn_t t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 || pend_q.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            t = pend_q.pop_front();
            req_operation <= t.op;
            req_address <= t.addr;
            req_write_value <= t.wv;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: ready follows a duty pattern whose period and duty are re-rolled at random
   int stall_cycle = 0;
   int stall_period = 1;
   int stall_duty = 1;
   always @(posedge clock) begin
      if (stall_cycle % 64 == 63) begin
         stall_period <= $urandom_range(1, 7);
         stall_duty <= $urandom_range(0, 3) == 0 ? 8 : $urandom_range(1, 7);
      end
      stall_cycle <= stall_cycle + 1;
      rsp_ready <= (stall_cycle % stall_period) < stall_duty;
   end

   // response checker
   always @(posedge clock) begin
      exec_rsp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (resp_q.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
         end else begin
            e = resp_q.pop_front();
            if (rsp_read_value !== e.rv) begin
               $error("read_value: expected %h actual %h", e.rv, rsp_read_value);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $error("status: expected %0d actual %0d", e.st, rsp_status);
               errors++;
            end
            if (rsp_program_counter !== e.pc) begin
               $error("program_counter: expected %h actual %h", e.pc, rsp_program_counter);
               errors++;
            end
            if (rsp_negative_flag !== e.n) begin
               $error("negative_flag: expected %b actual %b", e.n, rsp_negative_flag);
               errors++;
            end
            if (rsp_zero_flag !== e.z) begin
               $error("zero_flag: expected %b actual %b", e.z, rsp_zero_flag);
               errors++;
            end
            if (rsp_carry_flag !== e.c) begin
               $error("carry_flag: expected %b actual %b", e.c, rsp_carry_flag);
               errors++;
            end
         end
      end
   end
endmodule

/* files.f */
+incdir+design
design/msie_pkg.sv
design/msie_alu.sv
design/minicomputer_subset_instruction_executor.sv
test/minicomputer_subset_instruction_executor_tb.sv
